// ----- hw/rtl/uart_rb_pkg.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared constants, request and status codes, and pointer helpers.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);

   localparam int REQ_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int PEND_W   = 8;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [PEND_W-1:0] PENDING_MAX  = {PEND_W{1'b1}};

   typedef enum logic [REQ_W-1:0] {
      REQ_LINE_RX  = 3'd0,
      REQ_TX_DRAIN = 3'd1,
      REQ_PUT      = 3'd2,
      REQ_GET      = 3'd3,
      REQ_FLUSH_RX = 3'd4,
      REQ_FLUSH_TX = 3'd5,
      REQ_FLUSH_TO = 3'd6,
      REQ_TAKE_MSG = 3'd7
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_code_type;

   function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
      logic [RX_AW-1:0] r;
      if (p == RX_AW'(RX_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + RX_AW'(1);
      end
      return r;
   endfunction

   function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
      logic [TX_AW-1:0] r;
      if (p == TX_AW'(TX_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + TX_AW'(1);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/uart_rb_if.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer channels
// Valid/ready request and response channels with source and sink modports.
// ----------------------------------------------------------------------------
interface uart_rb_req_if;
   import uart_rb_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface uart_rb_rsp_if;
   import uart_rb_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic [STATUS_W-1:0] status;
   logic                msg_taken;
   logic                rx_nonempty;
   logic                tx_nonempty;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output msg_taken, output rx_nonempty, output tx_nonempty,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input msg_taken, input rx_nonempty, input tx_nonempty,
                   output ready);
endinterface

// ----- hw/rtl/uart_rx_tx_ring_buffers.sv -----
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// Two byte rings held in synchronous memories, with a pending-message count.
// ----------------------------------------------------------------------------
// Each transaction is accepted in the idle state, which issues the memory reads
// at the read pointers; the execute state then uses the registered read data,
// writes back and loads the response register. A flush-to request stays in the
// execute state while it discards bytes, since every compare waits on the
// registered read of the receive memory. A response that is not taken holds the
// block in its execute state; one waiting response does not stop a new
// transaction from being accepted.
module uart_rx_tx_ring_buffers (
   input  logic          clock,
   input  logic          reset,
   uart_rb_req_if.sink   req_if,
   uart_rb_rsp_if.source rsp_if
);
   import uart_rb_pkg::*;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type             state_ff, state_in;
   req_code_type          code_ff, code_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [RX_AW-1:0]      rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [TX_AW-1:0]      tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [PEND_W-1:0]     pend_ff, pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                  byte_valid_ff, byte_valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  msg_taken_ff, msg_taken_in;
   logic                  rx_ne_ff, rx_ne_in;
   logic                  tx_ne_ff, tx_ne_in;

   logic [BYTE_W-1:0]     rx_mem [RX_DEPTH];
   logic [BYTE_W-1:0]     tx_mem [TX_DEPTH];
   logic [BYTE_W-1:0]     rx_rdata_ff, tx_rdata_ff;
   logic [RX_AW-1:0]      rx_raddr;
   logic                  rx_we, tx_we;

   logic                  rx_empty, rx_full, tx_empty, tx_full, out_free, walk;

   assign rx_empty = (rx_rd_ff == rx_wr_ff);
   assign tx_empty = (tx_rd_ff == tx_wr_ff);
   assign rx_full  = (rx_next(rx_wr_ff) == rx_rd_ff);
   assign tx_full  = (tx_next(tx_wr_ff) == tx_rd_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign walk     = (code_ff == REQ_FLUSH_TO) && !rx_empty && (rx_rdata_ff != data_ff);

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = out_byte_ff;
   assign rsp_if.byte_valid  = byte_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.msg_taken   = msg_taken_ff;
   assign rsp_if.rx_nonempty = rx_ne_ff;
   assign rsp_if.tx_nonempty = tx_ne_ff;

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      data_in       = data_ff;
      rx_wr_in      = rx_wr_ff;
      rx_rd_in      = rx_rd_ff;
      tx_wr_in      = tx_wr_ff;
      tx_rd_in      = tx_rd_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      status_in     = status_ff;
      msg_taken_in  = msg_taken_ff;
      rx_ne_in      = rx_ne_ff;
      tx_ne_in      = tx_ne_ff;
      rx_we         = 1'b0;
      tx_we         = 1'b0;
      rx_raddr      = rx_rd_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               code_in  = req_code_type'(req_if.req_type);
               data_in  = req_if.data_byte;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (walk) begin
               // discard one byte and fetch the next
               rx_rd_in = rx_next(rx_rd_ff);
               rx_raddr = rx_rd_in;
            end else if (out_free) begin
               out_byte_in   = '0;
               byte_valid_in = 1'b0;
               status_in     = ST_OK;
               msg_taken_in  = 1'b0;
               unique case (code_ff)
                  REQ_LINE_RX: begin
                     if (rx_full) begin
                        status_in = ST_FULL;
                     end else begin
                        rx_we    = 1'b1;
                        rx_wr_in = rx_next(rx_wr_ff);
                        if (data_ff == NEWLINE_BYTE && pend_ff != PENDING_MAX) begin
                           pend_in = pend_ff + PEND_W'(1);
                        end
                     end
                  end
                  REQ_TX_DRAIN: begin
                     if (tx_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        out_byte_in   = tx_rdata_ff;
                        byte_valid_in = 1'b1;
                        tx_rd_in      = tx_next(tx_rd_ff);
                     end
                  end
                  REQ_PUT: begin
                     if (tx_full) begin
                        status_in = ST_FULL;
                     end else begin
                        tx_we    = 1'b1;
                        tx_wr_in = tx_next(tx_wr_ff);
                     end
                  end
                  REQ_GET: begin
                     if (rx_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        out_byte_in   = rx_rdata_ff;
                        byte_valid_in = 1'b1;
                        rx_rd_in      = rx_next(rx_rd_ff);
                     end
                  end
                  REQ_FLUSH_RX: rx_rd_in = rx_wr_ff;
                  REQ_FLUSH_TX: tx_rd_in = tx_wr_ff;
                  REQ_FLUSH_TO: ;
                  REQ_TAKE_MSG: begin
                     if (pend_ff != '0) begin
                        pend_in      = pend_ff - PEND_W'(1);
                        msg_taken_in = 1'b1;
                     end
                  end
               endcase
               rx_ne_in     = (rx_rd_in != rx_wr_in);
               tx_ne_in     = (tx_rd_in != tx_wr_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_wr_ff     <= rx_wr_in;
         rx_rd_ff     <= rx_rd_in;
         tx_wr_ff     <= tx_wr_in;
         tx_rd_ff     <= tx_rd_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff       <= code_in;
      data_ff       <= data_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      status_ff     <= status_in;
      msg_taken_ff  <= msg_taken_in;
      rx_ne_ff      <= rx_ne_in;
      tx_ne_ff      <= tx_ne_in;
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wr_ff] <= data_ff;
      end
      rx_rdata_ff <= rx_mem[rx_raddr];
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wr_ff] <= data_ff;
      end
      tx_rdata_ff <= tx_mem[tx_rd_ff];
   end

endmodule

// ----- hw/rtl/uart_rb_checker.sv -----
// ----------------------------------------------------------------------------
// UART ring buffer checker
// Port-level properties of the response channel, bound to the ring buffer module.
// ----------------------------------------------------------------------------
module uart_rb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [uart_rb_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                            rsp_byte_valid,
   input logic [uart_rb_pkg::STATUS_W-1:0] rsp_status,
   input logic                            rsp_msg_taken,
   input logic                            rsp_rx_nonempty,
   input logic                            rsp_tx_nonempty
);
   import uart_rb_pkg::*;

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == ST_OK)
      else $error("byte delivered with error status");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == '0)
      else $error("out_byte not cleared without a byte");

   a_msg_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_msg_taken |-> !rsp_byte_valid && rsp_status == ST_OK)
      else $error("message taken alongside byte or error");

   a_empty_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> !(rsp_rx_nonempty && rsp_tx_nonempty))
      else $error("empty status while both rings hold bytes");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind uart_rx_tx_ring_buffers uart_rb_checker u_uart_rb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_out_byte    (rsp_if.out_byte),
   .rsp_byte_valid  (rsp_if.byte_valid),
   .rsp_status      (rsp_if.status),
   .rsp_msg_taken   (rsp_if.msg_taken),
   .rsp_rx_nonempty (rsp_if.rx_nonempty),
   .rsp_tx_nonempty (rsp_if.tx_nonempty)
);

// ----- tb/sv/uart_rb_scoreboard_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer scoreboard
// Shadow copy of both byte rings and the pending-message count. Every accepted
// request is predicted here. Responses are checked in order, field by field.
// ----------------------------------------------------------------------------
package uart_rb_scoreboard_pkg;
   import uart_rb_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic                byte_valid;
      logic [STATUS_W-1:0] status;
      logic                msg_taken;
      logic                rx_nonempty;
      logic                tx_nonempty;
   } ring_rsp_type;

   class ring_scoreboard;
      logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
      logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
      logic [RX_AW-1:0]  rx_head;
      logic [RX_AW-1:0]  rx_tail;
      logic [TX_AW-1:0]  tx_head;
      logic [TX_AW-1:0]  tx_tail;
      logic [PEND_W-1:0] msgs_waiting;
      ring_rsp_type      expected_rsps [$];
      int                errors;

      function new();
         foreach (rx_ring[i]) rx_ring[i] = '0;
         foreach (tx_ring[i]) tx_ring[i] = '0;
         rx_head      = '0;
         rx_tail      = '0;
         tx_head      = '0;
         tx_tail      = '0;
         msgs_waiting = '0;
         errors       = 0;
      endfunction

      function void note_request(req_code_type code, logic [BYTE_W-1:0] data);
         ring_rsp_type     r;
         logic [RX_AW-1:0] rx_nx;
         logic [TX_AW-1:0] tx_nx;
         r     = '0;
         rx_nx = RX_AW'((rx_head + 1) % RX_DEPTH);
         tx_nx = TX_AW'((tx_head + 1) % TX_DEPTH);
         case (code)
            REQ_LINE_RX: begin
               if (rx_nx == rx_tail) begin
                  r.status = ST_FULL;
               end else begin
                  rx_ring[rx_head] = data;
                  if (data == NEWLINE_BYTE && msgs_waiting != PENDING_MAX) begin
                     msgs_waiting = msgs_waiting + 1'b1;
                  end
                  rx_head = rx_nx;
               end
            end
            REQ_TX_DRAIN: begin
               if (tx_tail == tx_head) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.out_byte   = tx_ring[tx_tail];
                  r.byte_valid = 1'b1;
                  tx_tail      = TX_AW'((tx_tail + 1) % TX_DEPTH);
               end
            end
            REQ_PUT: begin
               if (tx_nx == tx_tail) begin
                  r.status = ST_FULL;
               end else begin
                  tx_ring[tx_head] = data;
                  tx_head          = tx_nx;
               end
            end
            REQ_GET: begin
               if (rx_tail == rx_head) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.out_byte   = rx_ring[rx_tail];
                  r.byte_valid = 1'b1;
                  rx_tail      = RX_AW'((rx_tail + 1) % RX_DEPTH);
               end
            end
            REQ_FLUSH_RX: begin
               rx_tail = rx_head;
            end
            REQ_FLUSH_TX: begin
               tx_tail = tx_head;
            end
            REQ_FLUSH_TO: begin
               while (rx_tail != rx_head && rx_ring[rx_tail] != data) begin
                  rx_tail = RX_AW'((rx_tail + 1) % RX_DEPTH);
               end
            end
            default: begin
               if (msgs_waiting != '0) begin
                  msgs_waiting = msgs_waiting - 1'b1;
                  r.msg_taken  = 1'b1;
               end
            end
         endcase
         r.rx_nonempty = (rx_tail != rx_head);
         r.tx_nonempty = (tx_tail != tx_head);
         expected_rsps.push_back(r);
      endfunction

      function void compare_field(string name, logic [BYTE_W-1:0] want,
                                  logic [BYTE_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(ring_rsp_type got);
         ring_rsp_type want;
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_rsps.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("byte_valid", BYTE_W'(want.byte_valid), BYTE_W'(got.byte_valid));
         compare_field("status", BYTE_W'(want.status), BYTE_W'(got.status));
         compare_field("msg_taken", BYTE_W'(want.msg_taken), BYTE_W'(got.msg_taken));
         compare_field("rx_nonempty", BYTE_W'(want.rx_nonempty), BYTE_W'(got.rx_nonempty));
         compare_field("tx_nonempty", BYTE_W'(want.tx_nonempty), BYTE_W'(got.tx_nonempty));
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_uart_rx_tx_ring_buffers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer testbench
// Drives line bytes, software requests and transmitter drains through the
// request channel with random gaps and back-pressure, fills both rings to
// overflow, saturates the message count, and checks every response against
// a scoreboard that tracks both rings.
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers;
   import uart_rb_pkg::*;
   import uart_rb_scoreboard_pkg::*;

   localparam int QUIET_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int TOTAL_ITEMS     = 900;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit idle_on       = 1'b1;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int items_sent    = 0;

   ring_scoreboard board;

   uart_rb_req_if req_if ();
   uart_rb_rsp_if rsp_if ();

   uart_rx_tx_ring_buffers dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = RSP_HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !idle_on || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         board.check_response('{out_byte: rsp_if.out_byte, byte_valid: rsp_if.byte_valid,
                                status: rsp_if.status, msg_taken: rsp_if.msg_taken,
                                rx_nonempty: rsp_if.rx_nonempty,
                                tx_nonempty: rsp_if.tx_nonempty});
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_request(req_code_type code, logic [BYTE_W-1:0] data);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 34) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= code;
      req_if.data_byte <= data;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      board.note_request(code, data);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (board.expected_rsps.size() != 0);
      @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] text_byte();
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 3) == 0) begin
         b = NEWLINE_BYTE;
      end else if ($urandom_range(0, 4) == 0) begin
         b = BYTE_W'($urandom_range(0, 255));
      end else begin
         b = BYTE_W'(8'h61 + $urandom_range(0, 7));
      end
      return b;
   endfunction

   task automatic run_random_sequence();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            n = $urandom_range(1, 12);
            repeat (n) send_request(REQ_LINE_RX, text_byte());
            send_request(REQ_LINE_RX, NEWLINE_BYTE);
            if ($urandom_range(0, 1) == 1) send_request(REQ_TAKE_MSG, 8'($urandom()));
            repeat ($urandom_range(0, n + 2)) send_request(REQ_GET, 8'($urandom()));
         end
         4, 5: begin
            n = $urandom_range(1, 10);
            repeat (n) send_request(REQ_PUT, 8'($urandom()));
            repeat ($urandom_range(0, n + 2)) send_request(REQ_TX_DRAIN, 8'($urandom()));
         end
         6: send_request(REQ_FLUSH_TO, text_byte());
         7: send_request(req_code_type'($urandom_range(0, 7)), 8'($urandom()));
         8: send_request($urandom_range(0, 1) ? REQ_FLUSH_RX : REQ_FLUSH_TX,
                         8'($urandom()));
         default: send_request(REQ_TAKE_MSG, 8'($urandom()));
      endcase
   endtask

   task automatic run_mixed(int count);
      int stop;
      stop = items_sent + count;
      while (items_sent < stop) run_random_sequence();
   endtask

   initial begin
      board = new();
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_LINE_RX;
      req_if.data_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(REQ_GET, 8'hFF);
      send_request(REQ_TX_DRAIN, 8'h00);
      send_request(REQ_TAKE_MSG, 8'h00);
      send_request(REQ_FLUSH_TO, NEWLINE_BYTE);
      send_request(REQ_LINE_RX, 8'h00);
      send_request(REQ_LINE_RX, 8'hFF);
      send_request(REQ_LINE_RX, NEWLINE_BYTE);
      send_request(REQ_LINE_RX, 8'h41);
      send_request(REQ_TAKE_MSG, 8'hFF);
      send_request(REQ_GET, 8'h00);
      send_request(REQ_FLUSH_TO, 8'h41);
      send_request(REQ_GET, 8'h00);
      send_request(REQ_PUT, 8'h00);
      send_request(REQ_PUT, 8'hFF);
      send_request(REQ_TX_DRAIN, 8'hFF);
      send_request(REQ_FLUSH_TX, 8'h00);
      send_request(REQ_PUT, 8'h55);
      send_request(REQ_TX_DRAIN, 8'h00);
      send_request(REQ_LINE_RX, NEWLINE_BYTE);
      send_request(REQ_FLUSH_RX, 8'hFF);
      send_request(REQ_TAKE_MSG, 8'h00);
      send_request(REQ_TAKE_MSG, 8'h00);
      wait_drained();

      run_mixed(110);

      // hold responses back, which stalls further requests, and overflow the receive ring
      hold_requests <= hold_requests + 1;
      repeat (RX_DEPTH + 2) send_request(REQ_LINE_RX, text_byte());
      repeat (RX_DEPTH + 2) send_request(REQ_GET, 8'($urandom()));
      wait_drained();

      repeat (TX_DEPTH + 2) send_request(REQ_PUT, 8'($urandom()));
      repeat (TX_DEPTH + 2) send_request(REQ_TX_DRAIN, 8'($urandom()));

      idle_on <= 1'b0;
      run_mixed(120);
      idle_on <= 1'b1;

      // push the message count past its ceiling
      repeat (5) begin
         repeat (RX_DEPTH - 1) send_request(REQ_LINE_RX, NEWLINE_BYTE);
         send_request(REQ_FLUSH_RX, 8'($urandom()));
      end
      send_request(REQ_LINE_RX, NEWLINE_BYTE);
      repeat (3) send_request(REQ_TAKE_MSG, 8'($urandom()));
      wait_drained();

      while (items_sent < TOTAL_ITEMS) run_random_sequence();
      wait_drained();
      repeat (20) @(posedge clock);

      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
